FILE: src/trps_pkg.sv
// ----------------------------------------------------------------------------
// trps_pkg
// Shared widths, reset values and register indexes for the two-row pager.
// ----------------------------------------------------------------------------
package trps_pkg;

    // default build parameters
    localparam int DEF_MAX_MESSAGES = 16;
    localparam int DEF_COLUMNS      = 16;

    // field widths
    localparam int COUNT_W  = 5;
    localparam int DELAY_W  = 16;
    localparam int INDEX_W  = 4;
    localparam int LENGTH_W = 8;
    localparam int OFFSET_W = 8;
    localparam int CFG_IDX_W = 1;

    // page pointer holds values up to the largest count
    localparam int PAGE_W = COUNT_W;

    // timers
    localparam logic [DELAY_W-1:0] ELAPSED_MAX = {DELAY_W{1'b1}};
    localparam logic [DELAY_W-1:0] DELAY_RESET = 16'd1000;

    // request codes
    localparam logic REQ_TICK = 1'b0;
    localparam logic REQ_LOAD = 1'b1;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_MESSAGE_COUNT = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DELAY_TICKS   = 1'd1;

endpackage

FILE: src/trps_req_if.sv
// ----------------------------------------------------------------------------
// trps_req_if
// Request channel: a tick or a length load, with valid/ready handshake.
// ----------------------------------------------------------------------------
interface trps_req_if import trps_pkg::*; ();
    logic                valid;
    logic                ready;
    logic                req_type;
    logic [INDEX_W-1:0]  msg_index;
    logic [LENGTH_W-1:0] msg_length;

    modport source (output valid, output req_type, output msg_index,
                    output msg_length, input ready);
    modport sink   (input valid, input req_type, input msg_index,
                    input msg_length, output ready);
endinterface

FILE: src/trps_rsp_if.sv
// ----------------------------------------------------------------------------
// trps_rsp_if
// Result channel: the display window state after each request word.
// ----------------------------------------------------------------------------
interface trps_rsp_if import trps_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [INDEX_W-1:0]  first_row_index;
    logic [OFFSET_W-1:0] top_offset;
    logic [OFFSET_W-1:0] bottom_offset;
    logic                bottom_shown;
    logic                redraw;

    modport source (output valid, output first_row_index, output top_offset,
                    output bottom_offset, output bottom_shown, output redraw,
                    input ready);
    modport sink   (input valid, input first_row_index, input top_offset,
                    input bottom_offset, input bottom_shown, input redraw,
                    output ready);
endinterface

FILE: src/two_row_text_pager_scroller_top.sv
// ----------------------------------------------------------------------------
// two_row_text_pager_scroller_top
// Pages through stored message lengths two at a time and scrolls long rows.
// ----------------------------------------------------------------------------
// One request word is taken per clock cycle and its result word appears in
// the output register on the next cycle; a full output register that is not
// being taken holds off the request side. The throughput of one word a cycle
// is set by the page, offset and timer registers updating on each accepted word.
// The lengths of the two rows on show are kept in registers read from the length
// table at the next page's rows, with bypass of a length written in the same
// cycle. Lengths must be loaded before the pages that use them are shown;
// reset does not clear the table. Configuration writes are accepted at any
// time but should only be made while no word is in flight.
module two_row_text_pager_scroller_top import trps_pkg::*; #(
    parameter int MAX_MESSAGES = DEF_MAX_MESSAGES,
    parameter int COLUMNS      = DEF_COLUMNS
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    trps_req_if.sink             i_req,
    trps_rsp_if.source           o_rsp,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [DELAY_W-1:0]   i_cfg_data
);

    // only msg_index values below 16 can ever be loaded
    localparam int TBL_DEPTH = (MAX_MESSAGES < (1 << INDEX_W)) ? MAX_MESSAGES
                                                               : (1 << INDEX_W);
    localparam int AW = (TBL_DEPTH > 1) ? $clog2(TBL_DEPTH) : 1;
    localparam logic [LENGTH_W-1:0] COLS = LENGTH_W'(COLUMNS);

    // configuration
    logic [COUNT_W-1:0] r_message_count;
    logic [DELAY_W-1:0] r_delay_ticks;

    // pager state
    logic [PAGE_W-1:0]   r_page, n_page;
    logic [OFFSET_W-1:0] r_top_scroll, n_top_scroll;
    logic [OFFSET_W-1:0] r_bot_scroll, n_bot_scroll;
    logic                r_top_done, n_top_done;
    logic                r_bot_done, n_bot_done;
    logic [DELAY_W-1:0]  r_scroll_el, n_scroll_el;
    logic [DELAY_W-1:0]  r_page_el, n_page_el;
    logic                n_redraw;

    // length table and the two row lengths read from it
    logic [LENGTH_W-1:0] r_len_table [TBL_DEPTH];
    logic [LENGTH_W-1:0] r_top_len;
    logic [LENGTH_W-1:0] r_bot_len;

    // output register
    logic                r_out_valid;
    logic [INDEX_W-1:0]  r_out_first;
    logic [OFFSET_W-1:0] r_out_top;
    logic [OFFSET_W-1:0] r_out_bot;
    logic                r_out_shown;
    logic                r_out_redraw;

    logic                accept;
    logic [COUNT_W-1:0]  count;
    logic                top_here;
    logic                bot_here;
    logic [PAGE_W:0]     page_p1;
    logic [PAGE_W:0]     page_p2;
    logic [PAGE_W:0]     n_page_p1;
    logic                tbl_we;
    logic [AW-1:0]       wr_addr;
    logic [AW-1:0]       rd_top;
    logic [AW-1:0]       rd_bot;

    // handshake: output register parts the two sides
    assign i_req.ready = !r_out_valid || o_rsp.ready;
    assign accept      = i_req.valid && i_req.ready;

    // effective count, saturated at MAX_MESSAGES
    assign count = (32'(r_message_count) > MAX_MESSAGES) ? COUNT_W'(MAX_MESSAGES)
                                                         : r_message_count;

    assign page_p1  = {1'b0, r_page} + (PAGE_W+1)'(1);
    assign page_p2  = {1'b0, r_page} + (PAGE_W+1)'(2);
    assign top_here = r_page < count;
    assign bot_here = page_p1 < {1'b0, count};

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_message_count <= '0;
            r_delay_ticks   <= DELAY_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_MESSAGE_COUNT: r_message_count <= i_cfg_data[COUNT_W-1:0];
                REG_DELAY_TICKS:   r_delay_ticks   <= i_cfg_data;
                default:           ;
            endcase
        end
    end

    // next pager state for the word being accepted
    always_comb begin
        n_page       = r_page;
        n_top_scroll = r_top_scroll;
        n_bot_scroll = r_bot_scroll;
        n_top_done   = r_top_done;
        n_bot_done   = r_bot_done;
        n_scroll_el  = r_scroll_el;
        n_page_el    = r_page_el;
        n_redraw     = 1'b0;

        if (accept) begin
            if (i_req.req_type == REQ_LOAD) begin
                // restart at page 0
                n_page       = '0;
                n_top_scroll = '0;
                n_bot_scroll = '0;
                n_top_done   = 1'b0;
                n_bot_done   = 1'b0;
                n_scroll_el  = '0;
                n_page_el    = '0;
                n_redraw     = 1'b1;
            end else if (count != '0) begin
                // saturating timers
                if (r_scroll_el != ELAPSED_MAX) n_scroll_el = r_scroll_el + 1'b1;
                if (r_page_el != ELAPSED_MAX)   n_page_el   = r_page_el + 1'b1;

                // scroll step for both rows
                if (n_scroll_el >= r_delay_ticks) begin
                    n_scroll_el = '0;
                    n_redraw    = 1'b1;

                    if (top_here && (r_top_len > COLS) &&
                        (r_top_scroll < (r_top_len - COLS))) begin
                        n_top_scroll = r_top_scroll + 1'b1;
                        n_top_done   = 1'b0;
                    end else begin
                        n_top_done   = 1'b1;
                    end

                    if (bot_here && (r_bot_len > COLS) &&
                        (r_bot_scroll < (r_bot_len - COLS))) begin
                        n_bot_scroll = r_bot_scroll + 1'b1;
                        n_bot_done   = 1'b0;
                    end else begin
                        n_bot_done   = 1'b1;
                    end
                end

                // page advance once both rows have finished and the page timer has reached the delay
                if (n_top_done && n_bot_done && (n_page_el >= r_delay_ticks)) begin
                    n_page       = (page_p2 >= {1'b0, count}) ? '0
                                                              : page_p2[PAGE_W-1:0];
                    n_top_scroll = '0;
                    n_bot_scroll = '0;
                    n_top_done   = 1'b0;
                    n_bot_done   = 1'b0;
                    n_page_el    = '0;
                    n_redraw     = 1'b1;
                end
            end
        end
    end

    // pager state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_page       <= '0;
            r_top_scroll <= '0;
            r_bot_scroll <= '0;
            r_top_done   <= 1'b0;
            r_bot_done   <= 1'b0;
            r_scroll_el  <= '0;
            r_page_el    <= '0;
        end else begin
            r_page       <= n_page;
            r_top_scroll <= n_top_scroll;
            r_bot_scroll <= n_bot_scroll;
            r_top_done   <= n_top_done;
            r_bot_done   <= n_bot_done;
            r_scroll_el  <= n_scroll_el;
            r_page_el    <= n_page_el;
        end
    end

    // table ports: one write, two reads at the next page's rows
    assign n_page_p1 = {1'b0, n_page} + (PAGE_W+1)'(1);
    assign tbl_we    = accept && (i_req.req_type == REQ_LOAD) &&
                       (32'(i_req.msg_index) < TBL_DEPTH);
    assign wr_addr   = AW'(i_req.msg_index);
    assign rd_top    = i_rst_n ? AW'(n_page) : '0;
    assign rd_bot    = i_rst_n ? AW'(n_page_p1) : AW'(1);

    always_ff @(posedge i_clk) begin
        if (tbl_we) begin
            r_len_table[wr_addr] <= i_req.msg_length;
        end
        // bypass a length written in this cycle
        if (tbl_we && (wr_addr == rd_top)) begin
            r_top_len <= i_req.msg_length;
        end else begin
            r_top_len <= r_len_table[rd_top];
        end
        if (tbl_we && (wr_addr == rd_bot)) begin
            r_bot_len <= i_req.msg_length;
        end else begin
            r_bot_len <= r_len_table[rd_bot];
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (accept) begin
            r_out_valid <= 1'b1;
        end else if (o_rsp.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_out_first  <= n_page[INDEX_W-1:0];
            r_out_top    <= n_top_scroll;
            r_out_bot    <= n_bot_scroll;
            r_out_shown  <= n_page_p1 < {1'b0, count};
            r_out_redraw <= n_redraw;
        end
    end

    assign o_rsp.valid           = r_out_valid;
    assign o_rsp.first_row_index = r_out_first;
    assign o_rsp.top_offset      = r_out_top;
    assign o_rsp.bottom_offset   = r_out_bot;
    assign o_rsp.bottom_shown    = r_out_shown;
    assign o_rsp.redraw          = r_out_redraw;

endmodule

FILE: tb/two_row_text_pager_scroller_top_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// two_row_text_pager_scroller_top_tb
// Self-checking bench for the two-row pager: every request word is fed to a
// behavioural pager kept in a small scoreboard, and each result word is
// compared field by field with the oldest predicted window, under random
// sender bursts and receiver stalls and across a series of register settings.
// ----------------------------------------------------------------------------
module two_row_text_pager_scroller_top_tb import trps_pkg::*; ();

    localparam int MAX_MSG     = DEF_MAX_MESSAGES;
    localparam int COLS        = DEF_COLUMNS;
    localparam int CYCLE_LIMIT = 1000000;
    localparam int PHASE_WORDS = 75;
    localparam int NUM_PHASES  = 14;
    // longer delay run: a few scroll steps and a page turn
    localparam int HOLD_DELAY  = 40;
    localparam int HOLD_TICKS  = 200;

    typedef enum int {RX_ALWAYS, RX_RANDOM, RX_PERIODIC, RX_BURSTY} t_rx_mode;

    typedef struct packed {
        logic [INDEX_W-1:0]  first_row;
        logic [OFFSET_W-1:0] top_off;
        logic [OFFSET_W-1:0] bottom_off;
        logic                bottom_shown;
        logic                redraw;
    } t_window;

    // ------------------------------------------------------------------------
    // Scoreboard: pager state, register copies and the queue of due windows
    // ------------------------------------------------------------------------
    class pager_scoreboard;
        logic [LENGTH_W-1:0] lengths [MAX_MSG];
        int unsigned         page_start;
        logic [OFFSET_W-1:0] top_scroll;
        logic [OFFSET_W-1:0] bottom_scroll;
        bit                  top_done;
        bit                  bottom_done;
        logic [DELAY_W-1:0]  scroll_elapsed;
        logic [DELAY_W-1:0]  page_elapsed;
        logic [COUNT_W-1:0]  msg_count;
        logic [DELAY_W-1:0]  delay;
        t_window             windows_due [$];
        int                  errors, checked, words, loads, steps, turns, writes;

        function new();
            foreach (lengths[i]) lengths[i] = '0;
            msg_count = '0;
            delay     = DELAY_RESET;
            restart();
        endfunction

        function void restart();
            page_start     = 0;
            top_scroll     = '0;
            bottom_scroll  = '0;
            top_done       = 1'b0;
            bottom_done    = 1'b0;
            scroll_elapsed = '0;
            page_elapsed   = '0;
        endfunction

        // count saturates at the table depth
        function int unsigned live_count();
            return (msg_count > MAX_MSG) ? MAX_MSG : msg_count;
        endfunction

        function int outstanding();
            return windows_due.size();
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [DELAY_W-1:0] data);
            if (idx == REG_MESSAGE_COUNT)
                msg_count = data[COUNT_W-1:0];
            else if (idx == REG_DELAY_TICKS)
                delay = data;
            writes++;
        endfunction

        // one scroll step of one row; returns the new finished flag
        function bit scroll_row(bit present, int unsigned idx,
                                inout logic [OFFSET_W-1:0] offset);
            int unsigned len;
            if (!present || idx >= MAX_MSG)
                return 1'b1;
            len = lengths[idx];
            if (len <= COLS)
                return 1'b1;
            if (offset < len - COLS) begin
                offset = offset + 1'b1;
                return 1'b0;
            end
            return 1'b1;
        endfunction

        // advance the pager by one accepted request word
        function void note_word(logic kind, logic [INDEX_W-1:0] idx,
                                logic [LENGTH_W-1:0] len);
            int unsigned count;
            bit          refresh;
            bit          top_here;
            bit          bottom_here;
            t_window     w;
            count   = live_count();
            refresh = 1'b0;
            words++;
            if (kind == REQ_LOAD) begin
                lengths[idx] = len;
                restart();
                refresh = 1'b1;
                loads++;
            end else if (count != 0) begin
                top_here    = page_start < count;
                bottom_here = page_start + 1 < count;
                if (scroll_elapsed != ELAPSED_MAX)
                    scroll_elapsed++;
                if (page_elapsed != ELAPSED_MAX)
                    page_elapsed++;
                if (scroll_elapsed >= delay) begin
                    scroll_elapsed = '0;
                    top_done    = scroll_row(top_here, page_start, top_scroll);
                    bottom_done = scroll_row(bottom_here, page_start + 1, bottom_scroll);
                    refresh = 1'b1;
                    steps++;
                end
                if (top_done && bottom_done && page_elapsed >= delay) begin
                    page_start += 2;
                    if (page_start >= count)
                        page_start = 0;
                    top_scroll    = '0;
                    bottom_scroll = '0;
                    top_done      = 1'b0;
                    bottom_done   = 1'b0;
                    page_elapsed  = '0;
                    refresh = 1'b1;
                    turns++;
                end
            end
            w.first_row    = INDEX_W'(page_start);
            w.top_off      = top_scroll;
            w.bottom_off   = bottom_scroll;
            w.bottom_shown = (page_start + 1 < live_count());
            w.redraw       = refresh;
            windows_due.push_back(w);
        endfunction

        function void compare_field(string field, logic [OFFSET_W-1:0] want,
                                    logic [OFFSET_W-1:0] got);
            if (want !== got) begin
                $display("%0t: %s mismatch: expected %0d, actual %0d",
                         $time, field, want, got);
                errors++;
            end
        endfunction

        function void check_window(logic [INDEX_W-1:0] row, logic [OFFSET_W-1:0] top,
                                   logic [OFFSET_W-1:0] bottom, logic shown,
                                   logic refresh);
            t_window want;
            if (windows_due.size() == 0) begin
                $display("%0t: unexpected result word: expected none, actual row %0d",
                         $time, row);
                errors++;
                return;
            end
            want = windows_due.pop_front();
            checked++;
            compare_field("first_row_index", OFFSET_W'(want.first_row), OFFSET_W'(row));
            compare_field("top_offset", want.top_off, top);
            compare_field("bottom_offset", want.bottom_off, bottom);
            compare_field("bottom_shown", OFFSET_W'(want.bottom_shown), OFFSET_W'(shown));
            compare_field("redraw", OFFSET_W'(want.redraw), OFFSET_W'(refresh));
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // Signals and block under test
    // ------------------------------------------------------------------------
    logic                 i_clk;
    logic                 i_rst_n;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_idx;
    logic [DELAY_W-1:0]   cfg_data;

    trps_req_if req_if ();
    trps_rsp_if rsp_if ();

    two_row_text_pager_scroller_top dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req      (req_if),
        .o_rsp      (rsp_if),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data)
    );

    pager_scoreboard sb;
    t_rx_mode        rx_mode = RX_ALWAYS;
    int              stall_left = 0;
    int unsigned     cycles = 0;

    // clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // cycle limit
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("%0t: run stopped after %0d cycles", $time, cycles);
            $display("TEST FAILED");
            $finish;
        end
    end

    // receiver back-pressure, pattern chosen per phase
    always @(posedge i_clk) begin
        case (rx_mode)
            RX_ALWAYS: begin
                rsp_if.ready <= 1'b1;
            end
            RX_RANDOM: begin
                rsp_if.ready <= ($urandom_range(3, 0) != 0);
            end
            RX_PERIODIC: begin
                rsp_if.ready <= ((cycles % 7) >= 3);
            end
            default: begin
                if (stall_left > 0) begin
                    stall_left   <= stall_left - 1;
                    rsp_if.ready <= 1'b0;
                end else if ($urandom_range(19, 0) == 0) begin
                    stall_left   <= $urandom_range(12, 1);
                    rsp_if.ready <= 1'b0;
                end else begin
                    rsp_if.ready <= 1'b1;
                end
            end
        endcase
    end

    // check result words, then note request words taken at this edge
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (rsp_if.valid && rsp_if.ready)
                sb.check_window(rsp_if.first_row_index, rsp_if.top_offset,
                                rsp_if.bottom_offset, rsp_if.bottom_shown,
                                rsp_if.redraw);
            if (req_if.valid && req_if.ready)
                sb.note_word(req_if.req_type, req_if.msg_index, req_if.msg_length);
        end
    end

    // ------------------------------------------------------------------------
    // Driving tasks
    // ------------------------------------------------------------------------
    // present one word and hold it until taken
    task automatic send_word(input logic kind, input logic [INDEX_W-1:0] idx,
                             input logic [LENGTH_W-1:0] len);
        req_if.valid      <= 1'b1;
        req_if.req_type   <= kind;
        req_if.msg_index  <= idx;
        req_if.msg_length <= len;
        do @(posedge i_clk); while (req_if.ready !== 1'b1);
    endtask

    // gap between bursts; n must be at least one
    task automatic pause_sender(input int n);
        req_if.valid <= 1'b0;
        repeat (n) @(posedge i_clk);
    endtask

    // hold off until every due window has been checked
    task automatic drain();
        req_if.valid <= 1'b0;
        do @(posedge i_clk); while (sb.outstanding() != 0);
        repeat (2) @(posedge i_clk);
    endtask

    // write both registers; only called once drained
    task automatic configure(input logic [COUNT_W-1:0] count,
                             input logic [DELAY_W-1:0] delay);
        cfg_we   <= 1'b1;
        cfg_idx  <= REG_MESSAGE_COUNT;
        cfg_data <= DELAY_W'(count);
        @(posedge i_clk);
        sb.write_reg(REG_MESSAGE_COUNT, DELAY_W'(count));
        cfg_idx  <= REG_DELAY_TICKS;
        cfg_data <= delay;
        @(posedge i_clk);
        sb.write_reg(REG_DELAY_TICKS, delay);
        cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    // mostly rows that fit or scroll a few steps, now and then a long one
    function automatic logic [LENGTH_W-1:0] pick_length();
        int unsigned r;
        r = $urandom_range(99, 0);
        if (r < 35)
            return LENGTH_W'($urandom_range(COLS, 0));
        if (r < 80)
            return LENGTH_W'($urandom_range(COLS + 6, COLS + 1));
        if (r < 95)
            return LENGTH_W'($urandom_range(60, COLS + 7));
        return LENGTH_W'($urandom_range(255, 61));
    endfunction

    // random ticks with occasional loads, sent in bursts when gaps is set
    task automatic run_phase(input int n_words, input int load_pct, input bit gaps);
        int  burst_left;
        logic kind;
        burst_left = $urandom_range(24, 0);
        for (int k = 0; k < n_words; k++) begin
            kind = ($urandom_range(99, 0) < load_pct) ? REQ_LOAD : REQ_TICK;
            send_word(kind, INDEX_W'($urandom_range(MAX_MSG - 1, 0)), pick_length());
            if (burst_left > 0) begin
                burst_left--;
            end else begin
                if (gaps)
                    pause_sender($urandom_range(6, 1));
                burst_left = $urandom_range(24, 0);
            end
            if ($urandom_range(199, 0) == 0)
                drain();
        end
    endtask

    // longer delay: top row scrolls twice, then the page turns and wraps
    task automatic run_long_hold();
        drain();
        configure(COUNT_W'(2), DELAY_W'(HOLD_DELAY));
        rx_mode = RX_ALWAYS;
        send_word(REQ_LOAD, INDEX_W'(0), LENGTH_W'(COLS + 2));
        send_word(REQ_LOAD, INDEX_W'(1), LENGTH_W'(5));
        repeat (HOLD_TICKS)
            send_word(REQ_TICK, INDEX_W'($urandom_range(MAX_MSG - 1, 0)),
                      LENGTH_W'($urandom_range(255, 0)));
        drain();
    endtask

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------
    initial begin
        logic [LENGTH_W-1:0] first_lengths [MAX_MSG];
        int                  phase_count [12];
        int                  phase_delay [12];
        int                  count_sel;
        int                  delay_sel;

        first_lengths = '{17, 0, 16, 20, 18, 1, 2, 19, 24, 33, 21, 16, 3, 17, 22, 255};
        phase_count   = '{16, 31, 3, 1, 0, 2, 17, 20, 5, 4, 15, 2};
        phase_delay   = '{0, 1, 2, 0, 3, 20, 1, 0, 4, 2, 1, 0};

        sb = new();
        i_rst_n           <= 1'b0;
        cfg_we            <= 1'b0;
        cfg_idx           <= REG_MESSAGE_COUNT;
        cfg_data          <= '0;
        req_if.valid      <= 1'b0;
        req_if.req_type   <= REQ_TICK;
        req_if.msg_index  <= '0;
        req_if.msg_length <= '0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: idle tick with no messages, fill the table, then a short
        // run at zero delay with an odd count so the bottom row drops out
        send_word(REQ_TICK, '1, '1);
        for (int i = 0; i < MAX_MSG; i++)
            send_word(REQ_LOAD, INDEX_W'(i), first_lengths[i]);
        drain();
        configure(COUNT_W'(3), DELAY_W'(0));
        repeat (8)
            send_word(REQ_TICK, INDEX_W'($urandom_range(MAX_MSG - 1, 0)),
                      LENGTH_W'($urandom_range(255, 0)));
        drain();

        // random phases; the first three carry no loads so pages keep moving
        // and a lowered count finds the page beyond the end
        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            if (ph == 6)
                run_long_hold();
            if (ph < 12) begin
                count_sel = phase_count[ph];
                delay_sel = phase_delay[ph];
            end else begin
                count_sel = $urandom_range(31, 0);
                delay_sel = $urandom_range(6, 0);
            end
            drain();
            configure(COUNT_W'(count_sel), DELAY_W'(delay_sel));
            rx_mode = t_rx_mode'(ph % 4);
            run_phase(PHASE_WORDS, (ph < 3) ? 0 : 5, (ph % 4) != 0);
        end
        drain();

        $display("Sent %0d words (%0d loads) over %0d register writes; %0d results checked.",
                 sb.words, sb.loads, sb.writes, sb.checked);
        $display("Pager made %0d scroll steps and %0d page turns; %0d mismatches.",
                 sb.steps, sb.turns, sb.errors);
        if (sb.errors == 0 && sb.outstanding() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
